>>> src/assert_macros.svh
// Assertion macros used by the battery thermal charge policy core.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BTCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion lbl failed");
`define BTCP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion lbl failed");
`else
`define BTCP_ASSERT(lbl, prop)
`define BTCP_ASSERT_RST(lbl, prop)
`endif
`endif

>>> src/btcp_pkg.sv
// Types, codes and constants for the battery thermal charge policy.
// No dependencies.
package btcp_pkg;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  // APB register map, word addressed
  typedef enum logic [REG_IDX_W-1:0] {
    REG_COLD_LIMIT      = 3'd0,
    REG_NORMAL_LIMIT    = 3'd1,
    REG_WARM_LIMIT      = 3'd2,
    REG_HOT_LIMIT       = 3'd3,
    REG_VOLTAGE_LIMIT   = 3'd4,
    REG_REDUCED_CURRENT = 3'd5,
    REG_DEFAULT_CURRENT = 3'd6,
    REG_FILTER_ENABLE   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    BAND_COLD = 3'd0,
    BAND_NORM = 3'd1,
    BAND_WARM = 3'd2,
    BAND_HOT  = 3'd3,
    BAND_OVER = 3'd4
  } band_e;

  // policy state machine, one-hot
  typedef enum logic [2:0] {
    ST_NORMAL  = 3'b001,
    ST_REDUCED = 3'b010,
    ST_STOPPED = 3'b100
  } policy_state_e;

  // reported charge state
  localparam logic [1:0] CHG_NORMAL  = 2'd0;
  localparam logic [1:0] CHG_REDUCED = 2'd1;
  localparam logic [1:0] CHG_STOPPED = 2'd2;

  // transition codes
  localparam logic [2:0] TR_NONE        = 3'd0;
  localparam logic [2:0] TR_NORM_TO_RED = 3'd1;
  localparam logic [2:0] TR_NORM_TO_STP = 3'd2;
  localparam logic [2:0] TR_RED_TO_NORM = 3'd3;
  localparam logic [2:0] TR_RED_TO_STP  = 3'd4;
  localparam logic [2:0] TR_STP_TO_NORM = 3'd5;
  localparam logic [2:0] TR_STP_TO_RED  = 3'd6;

  // health codes
  localparam logic [1:0] HEALTH_GOOD     = 2'd0;
  localparam logic [1:0] HEALTH_OVERHEAT = 2'd1;
  localparam logic [1:0] HEALTH_COLD     = 2'd2;

  // repeat filter window
  localparam logic signed [7:0] FILT_TEMP_LO  = 8'sd40;
  localparam logic signed [7:0] FILT_TEMP_HI  = 8'sd50;
  localparam logic signed [8:0] FILT_DIFF_MIN = -9'sd2;
  localparam logic signed [8:0] FILT_DIFF_MAX = 9'sd3;
  localparam logic signed [7:0] TEMP_RESET    = 8'sd25;
  localparam logic [1:0]        REPEAT_RESET  = 2'd1;
  localparam logic [1:0]        REPEAT_HOLD   = 2'd2;
  localparam logic [1:0]        REPEAT_MAX    = 2'd3;

  typedef struct packed {
    logic signed [7:0] battery_temp;
    logic [22:0]       battery_voltage;
    logic              charger_present;
    logic              charger_changed;
    logic [11:0]       thermal_current;
    logic [11:0]       max_current;
  } in_t;

  typedef struct packed {
    logic [1:0]  charge_state;
    logic [2:0]  transition;
    logic        update_req;
    logic        disable_charging;
    logic [11:0] drive_current;
    logic [1:0]  health;
    logic        pseudo_charging;
  } out_t;

  typedef struct packed {
    logic signed [7:0] cold_limit;
    logic signed [7:0] normal_limit;
    logic signed [7:0] warm_limit;
    logic signed [7:0] hot_limit;
    logic [22:0]       voltage_limit;
    logic [11:0]       reduced_current;
    logic [11:0]       default_current;
    logic              filter_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cold_limit:      -8'sd5,
    normal_limit:    8'sd41,
    warm_limit:      8'sd44,
    hot_limit:       8'sd52,
    voltage_limit:   23'd4000000,
    reduced_current: 12'd450,
    default_current: 12'd1000,
    filter_enable:   1'b1
  };

endpackage

>>> src/btcp_cfg_regs.sv
// APB configuration registers of the charge policy.
// Depends on btcp_pkg.
module btcp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [btcp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output btcp_pkg::cfg_t              cfg_o
);
  import btcp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_COLD_LIMIT:      cfg_d.cold_limit      = pwdata[7:0];
        REG_NORMAL_LIMIT:    cfg_d.normal_limit    = pwdata[7:0];
        REG_WARM_LIMIT:      cfg_d.warm_limit      = pwdata[7:0];
        REG_HOT_LIMIT:       cfg_d.hot_limit       = pwdata[7:0];
        REG_VOLTAGE_LIMIT:   cfg_d.voltage_limit   = pwdata[22:0];
        REG_REDUCED_CURRENT: cfg_d.reduced_current = pwdata[11:0];
        REG_DEFAULT_CURRENT: cfg_d.default_current = pwdata[11:0];
        REG_FILTER_ENABLE:   cfg_d.filter_enable   = pwdata[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COLD_LIMIT:      prdata = {24'd0, cfg_q.cold_limit};
      REG_NORMAL_LIMIT:    prdata = {24'd0, cfg_q.normal_limit};
      REG_WARM_LIMIT:      prdata = {24'd0, cfg_q.warm_limit};
      REG_HOT_LIMIT:       prdata = {24'd0, cfg_q.hot_limit};
      REG_VOLTAGE_LIMIT:   prdata = {9'd0, cfg_q.voltage_limit};
      REG_REDUCED_CURRENT: prdata = {20'd0, cfg_q.reduced_current};
      REG_DEFAULT_CURRENT: prdata = {20'd0, cfg_q.default_current};
      REG_FILTER_ENABLE:   prdata = {31'd0, cfg_q.filter_enable};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/btcp_temp_band.sv
// Warm-temperature repeat filter and five-band temperature classifier.
// Depends on btcp_pkg.
module btcp_temp_band (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  btcp_pkg::cfg_t          cfg_i,
  input  logic signed [7:0]       temp_i,
  output btcp_pkg::band_e         band_o
);
  import btcp_pkg::*;

  logic signed [7:0] prev_q, prev_d;
  logic [1:0]        rpt_q, rpt_d;
  logic signed [8:0] diff;
  logic              in_win;
  logic [1:0]        rpt_inc;
  logic signed [7:0] filt_temp;
  logic signed [7:0] use_temp;

  assign diff   = {temp_i[7], temp_i} - {prev_q[7], prev_q};
  assign in_win = (temp_i >= FILT_TEMP_LO) && (temp_i <= FILT_TEMP_HI) &&
                  (diff > FILT_DIFF_MIN) && (diff < FILT_DIFF_MAX);

  always_comb begin
    rpt_inc = rpt_q;
    if ((temp_i == prev_q) && (rpt_q < REPEAT_MAX)) begin
      rpt_inc = rpt_q + 2'd1;
    end
    if (in_win) begin
      if (rpt_inc >= REPEAT_HOLD) begin
        rpt_d     = REPEAT_RESET;
        filt_temp = temp_i;
      end else begin
        rpt_d     = rpt_inc;
        filt_temp = prev_q;
      end
    end else begin
      rpt_d     = REPEAT_RESET;
      filt_temp = temp_i;
    end
  end

  assign use_temp = cfg_i.filter_enable ? filt_temp : temp_i;
  assign prev_d   = filt_temp;

  // first match wins, so out-of-order limits still give one band
  always_comb begin
    priority if (use_temp > cfg_i.hot_limit) begin
      band_o = BAND_OVER;
    end else if (use_temp > cfg_i.warm_limit) begin
      band_o = BAND_HOT;
    end else if (use_temp > cfg_i.normal_limit) begin
      band_o = BAND_WARM;
    end else if (use_temp > cfg_i.cold_limit) begin
      band_o = BAND_NORM;
    end else begin
      band_o = BAND_COLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= TEMP_RESET;
      rpt_q  <= REPEAT_RESET;
    end else if (step_i && cfg_i.filter_enable) begin
      prev_q <= prev_d;
      rpt_q  <= rpt_d;
    end
  end

endmodule

>>> src/btcp_policy.sv
// Charge policy state machine, current selection and update-request logic.
// Depends on btcp_pkg.
module btcp_policy (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  btcp_pkg::cfg_t  cfg_i,
  input  btcp_pkg::in_t   item_i,
  input  btcp_pkg::band_e band_i,
  output btcp_pkg::out_t  res_o
);
  import btcp_pkg::*;

  policy_state_e state_q, state_d, state_start;
  logic          pseudo_q, pseudo_d;
  logic          last_chg_q, last_chg_d;
  logic [11:0]   last_cur_q;
  logic          chg_evt, attach;
  logic          high_v;
  logic [2:0]    trans;
  logic [11:0]   cur;
  logic [1:0]    chg_st;
  logic [11:0]   min_max, min_red;

  assign chg_evt    = (item_i.charger_present != last_chg_q) | item_i.charger_changed;
  assign attach     = chg_evt & item_i.charger_present;
  assign last_chg_d = chg_evt ? item_i.charger_present : last_chg_q;
  assign high_v     = item_i.battery_voltage >= cfg_i.voltage_limit;

  // a charger attach restarts from normal before the update
  assign state_start = attach ? ST_NORMAL : state_q;

  always_comb begin
    state_d  = state_start;
    pseudo_d = pseudo_q;
    trans    = TR_NONE;
    unique case (state_start)
      ST_NORMAL: begin
        if ((band_i == BAND_OVER) || (band_i == BAND_COLD)) begin
          trans = TR_NORM_TO_STP; pseudo_d = 1'b0; state_d = ST_STOPPED;
        end else if (band_i == BAND_HOT) begin
          if (high_v) begin
            trans = TR_NORM_TO_STP; pseudo_d = 1'b1; state_d = ST_STOPPED;
          end else begin
            trans = TR_NORM_TO_RED; pseudo_d = 1'b0; state_d = ST_REDUCED;
          end
        end
      end
      ST_REDUCED: begin
        if (band_i == BAND_OVER) begin
          trans = TR_RED_TO_STP; pseudo_d = 1'b0; state_d = ST_STOPPED;
        end else if ((band_i == BAND_COLD) || (band_i == BAND_NORM)) begin
          trans = TR_RED_TO_NORM; pseudo_d = 1'b0; state_d = ST_NORMAL;
        end else if (high_v) begin
          trans = TR_RED_TO_STP; pseudo_d = 1'b1; state_d = ST_STOPPED;
        end
      end
      ST_STOPPED: begin
        if ((band_i == BAND_NORM) || (band_i == BAND_WARM)) begin
          trans = TR_STP_TO_NORM; pseudo_d = 1'b0; state_d = ST_NORMAL;
        end else if (band_i == BAND_HOT) begin
          if (!high_v) begin
            trans = TR_STP_TO_RED; pseudo_d = 1'b0; state_d = ST_REDUCED;
          end else begin
            pseudo_d = 1'b1;
          end
        end else if (band_i == BAND_OVER) begin
          pseudo_d = 1'b0;
        end
      end
      default: begin
        state_d = state_start;
      end
    endcase
  end

  assign min_max = (item_i.thermal_current <= item_i.max_current) ?
                   item_i.thermal_current : item_i.max_current;
  assign min_red = (item_i.thermal_current <= cfg_i.reduced_current) ?
                   item_i.thermal_current : cfg_i.reduced_current;

  always_comb begin
    unique case (state_d)
      ST_NORMAL: begin
        cur    = min_max;
        chg_st = CHG_NORMAL;
      end
      ST_REDUCED: begin
        cur    = min_red;
        chg_st = CHG_REDUCED;
      end
      ST_STOPPED: begin
        cur    = cfg_i.default_current;
        chg_st = CHG_STOPPED;
      end
      default: begin
        cur    = cfg_i.default_current;
        chg_st = CHG_STOPPED;
      end
    endcase
  end

  always_comb begin
    res_o.charge_state     = chg_st;
    res_o.transition       = trans;
    res_o.update_req       = attach | (cur != last_cur_q);
    res_o.disable_charging = (state_d == ST_STOPPED);
    res_o.drive_current    = cur;
    res_o.pseudo_charging  = pseudo_d;
    unique case (band_i)
      BAND_OVER: res_o.health = HEALTH_OVERHEAT;
      BAND_COLD: res_o.health = HEALTH_COLD;
      default:   res_o.health = HEALTH_GOOD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_NORMAL;
      pseudo_q   <= 1'b0;
      last_chg_q <= 1'b0;
      last_cur_q <= '0;
    end else if (step_i) begin
      state_q    <= state_d;
      pseudo_q   <= pseudo_d;
      last_chg_q <= last_chg_d;
      last_cur_q <= cur;
    end
  end

endmodule

>>> src/battery_thermal_charge_policy_core.sv
// Top level of the battery thermal charge policy: input stage, policy logic
// and result register. Depends on btcp_pkg, btcp_cfg_regs, btcp_temp_band,
// btcp_policy and assert_macros.svh.
//
// Usage
// - Input channel (in_valid_i / in_ready_o / in_data_i) carries one battery
//   sample per transfer; output channel (out_valid_o / out_ready_i /
//   out_data_o) returns exactly one result per sample, in order.
// - A sample accepted into the input register has its result loaded into the
//   result register once that register is free or drains, and out_valid_o
//   rises with that load.
// - Throughput: one sample per clock while out_ready_i is high. The whole
//   policy update (filter, band compare, state machine, current select) is a
//   single combinational pass between the input and result registers.
// - Stall: while out_ready_i is low the result is held; the input register
//   still takes one more sample, so in_ready_o drops only once both the
//   input stage and the result register are full.
// - Reset (rst_ni low, asynchronous) empties both stages, puts the policy in
//   the normal state and loads the register defaults.
// - Configuration goes through the APB port (pready always high, registers at byte
//   address 4*index); the user must change it only while the block is idle (not enforced).
`include "assert_macros.svh"
module battery_thermal_charge_policy_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  btcp_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output btcp_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [btcp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import btcp_pkg::*;

  cfg_t  cfg;
  in_t   in_q;
  logic  s1_valid_q;
  logic  s1_adv;
  logic  step;
  band_e band;
  out_t  res;
  out_t  out_q;
  logic  out_valid_q;

  btcp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage moves on whenever the result register is free or drains
  assign s1_adv     = ~out_valid_q | out_ready_i;
  assign step       = s1_valid_q & s1_adv;
  assign in_ready_o = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  btcp_temp_band u_band (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .temp_i (in_q.battery_temp),
    .band_o (band)
  );

  btcp_policy u_policy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .item_i (in_q),
    .band_i (band),
    .res_o  (res)
  );

  // result register; policy state advances in the same edge as the load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BTCP_ASSERT_RST(a_reset_empties_output, !rst_ni |-> !out_valid_q)
  `BTCP_ASSERT(a_ready_low_only_when_full, !in_ready_o |-> s1_valid_q && out_valid_q)
  `BTCP_ASSERT(a_stalled_item_kept, s1_valid_q && !s1_adv |=> s1_valid_q)
  `BTCP_ASSERT(a_overheat_stops, out_valid_q && out_q.health == HEALTH_OVERHEAT |-> out_q.charge_state == CHG_STOPPED)
  `BTCP_ASSERT(a_cold_never_reduced, out_valid_q && out_q.health == HEALTH_COLD |-> out_q.charge_state != CHG_REDUCED)

endmodule

>>> test/battery_thermal_charge_policy_core_tb.sv
// Self-checking testbench for battery_thermal_charge_policy_core.
// Drives samples and APB register writes, predicts each result in-line;
// needs btcp_pkg and the core RTL only.
`timescale 1ns / 100ps

module battery_thermal_charge_policy_core_tb;
  import btcp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SAMPLES = 165;
  localparam int MAX_VOLT      = 5000000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // DUT ports
  logic              in_valid  = 1'b0;
  logic              in_ready_o;
  in_t               in_data   = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  out_t              out_data_o;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  battery_thermal_charge_policy_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // stimulus and scoreboard storage
  in_t  pending_samples[$];
  out_t policy_results_q[$];
  out_t want;
  int   send_idle_pct = 34;
  int   recv_idle_pct = 82;
  int   error_count   = 0;
  int   samples_taken = 0;
  int   results_seen  = 0;
  int   settings_used = 1;
  int   cycle_count   = 0;

  // shadow of the policy: configuration and state
  cfg_t          cfg;
  policy_state_e pol_state;
  logic          pseudo_flag;
  logic          last_charger;
  logic [11:0]   last_current;
  int            prev_temp;
  int            repeat_cnt;

  // generator memory, keeps random samples in plausible sequences
  int   gen_temp    = 25;
  logic gen_present = 1'b0;

  task automatic reset_policy();
    cfg          = CFG_RESET;
    pol_state    = ST_NORMAL;
    pseudo_flag  = 1'b0;
    last_charger = 1'b0;
    last_current = '0;
    prev_temp    = int'(TEMP_RESET);
    repeat_cnt   = int'(REPEAT_RESET);
  endtask

  // One policy update per accepted sample; returns the result it owes.
  function automatic out_t charge_policy_step(in_t s);
    int          t;
    int          d;
    band_e       band;
    logic        high_v;
    logic        force_up;
    logic [2:0]  tr;
    logic [11:0] cur;
    out_t        r;
    t        = int'($signed(s.battery_temp));
    high_v   = s.battery_voltage >= cfg.voltage_limit;
    force_up = 1'b0;
    tr       = TR_NONE;

    // a charger change event with the charger present restarts in normal
    if ((s.charger_present != last_charger) || s.charger_changed) begin
      last_charger = s.charger_present;
      if (s.charger_present) begin
        pol_state = ST_NORMAL;
        force_up  = 1'b1;
      end
    end

    // warm repeat filter: small steps inside the window are held back
    if (cfg.filter_enable) begin
      d = t - prev_temp;
      if (t >= int'(FILT_TEMP_LO) && t <= int'(FILT_TEMP_HI) &&
          d > int'(FILT_DIFF_MIN) && d < int'(FILT_DIFF_MAX)) begin
        if (t == prev_temp && repeat_cnt < int'(REPEAT_MAX)) repeat_cnt++;
        if (repeat_cnt >= int'(REPEAT_HOLD)) repeat_cnt = int'(REPEAT_RESET);
        else t = prev_temp;
      end else begin
        repeat_cnt = int'(REPEAT_RESET);
      end
      prev_temp = t;
    end

    // first hit wins, so out-of-order limits still give one band
    if (t > int'($signed(cfg.hot_limit)))         band = BAND_OVER;
    else if (t > int'($signed(cfg.warm_limit)))   band = BAND_HOT;
    else if (t > int'($signed(cfg.normal_limit))) band = BAND_WARM;
    else if (t > int'($signed(cfg.cold_limit)))   band = BAND_NORM;
    else                                          band = BAND_COLD;

    case (pol_state)
      ST_NORMAL: begin
        if (band == BAND_OVER || band == BAND_COLD) begin
          tr = TR_NORM_TO_STP; pseudo_flag = 1'b0; pol_state = ST_STOPPED;
        end else if (band == BAND_HOT) begin
          if (high_v) begin
            tr = TR_NORM_TO_STP; pseudo_flag = 1'b1; pol_state = ST_STOPPED;
          end else begin
            tr = TR_NORM_TO_RED; pseudo_flag = 1'b0; pol_state = ST_REDUCED;
          end
        end
      end
      ST_REDUCED: begin
        // cold goes back to normal first; a next cold sample stops it
        if (band == BAND_OVER) begin
          tr = TR_RED_TO_STP; pseudo_flag = 1'b0; pol_state = ST_STOPPED;
        end else if (band == BAND_COLD || band == BAND_NORM) begin
          tr = TR_RED_TO_NORM; pseudo_flag = 1'b0; pol_state = ST_NORMAL;
        end else if (high_v) begin
          tr = TR_RED_TO_STP; pseudo_flag = 1'b1; pol_state = ST_STOPPED;
        end
      end
      ST_STOPPED: begin
        if (band == BAND_NORM || band == BAND_WARM) begin
          tr = TR_STP_TO_NORM; pseudo_flag = 1'b0; pol_state = ST_NORMAL;
        end else if (band == BAND_HOT) begin
          if (!high_v) begin
            tr = TR_STP_TO_RED; pseudo_flag = 1'b0; pol_state = ST_REDUCED;
          end else begin
            pseudo_flag = 1'b1;
          end
        end else if (band == BAND_OVER) begin
          pseudo_flag = 1'b0;
        end
      end
      default: ;
    endcase

    case (pol_state)
      ST_NORMAL:  cur = (s.thermal_current <= s.max_current) ?
                        s.thermal_current : s.max_current;
      ST_REDUCED: cur = (s.thermal_current <= cfg.reduced_current) ?
                        s.thermal_current : cfg.reduced_current;
      default:    cur = cfg.default_current;
    endcase

    if (cur != last_current) begin
      last_current = cur;
      force_up     = 1'b1;
    end

    case (pol_state)
      ST_NORMAL:  r.charge_state = CHG_NORMAL;
      ST_REDUCED: r.charge_state = CHG_REDUCED;
      ST_STOPPED: r.charge_state = CHG_STOPPED;
      default:    r.charge_state = '1;
    endcase
    r.transition       = tr;
    r.update_req       = force_up;
    r.disable_charging = (pol_state == ST_STOPPED);
    r.drive_current    = cur;
    r.health           = (band == BAND_OVER) ? HEALTH_OVERHEAT :
                         (band == BAND_COLD) ? HEALTH_COLD : HEALTH_GOOD;
    r.pseudo_charging  = pseudo_flag;
    return r;
  endfunction

  function automatic in_t mk_sample(int t, int v, int pres, int chg, int th, int mx);
    in_t s;
    s.battery_temp    = t[7:0];
    s.battery_voltage = v[22:0];
    s.charger_present = pres[0];
    s.charger_changed = chg[0];
    s.thermal_current = th[11:0];
    s.max_current     = mx[11:0];
    return s;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Mostly well-formed sequences around the live limits, a quarter noise.
  function automatic in_t gen_sample();
    int t;
    int v;
    int th;
    int mx;
    int lim;
    int k;
    bit chg;
    if ($urandom_range(99) < 25) begin
      gen_present = 1'($urandom_range(1));
      return mk_sample($urandom_range(255), $urandom_range(MAX_VOLT), int'(gen_present),
                       $urandom_range(1), $urandom_range(4095), $urandom_range(4095));
    end
    k = $urandom_range(9);
    if (k <= 5) begin
      case ($urandom_range(3))
        0:       lim = int'($signed(cfg.cold_limit));
        1:       lim = int'($signed(cfg.normal_limit));
        2:       lim = int'($signed(cfg.warm_limit));
        default: lim = int'($signed(cfg.hot_limit));
      endcase
      t = lim + int'($urandom_range(4)) - 2;
    end else if (k <= 7) begin
      t = gen_temp + int'($urandom_range(4)) - 1;
      if (t < 38 || t > 52) t = 38 + int'($urandom_range(14));
    end else if (k == 8) begin
      t = gen_temp;
    end else begin
      t = int'($urandom_range(255)) - 128;
    end
    t        = clamp(t, -128, 127);
    gen_temp = t;
    if ($urandom_range(1))
      v = clamp(int'(cfg.voltage_limit) + int'($urandom_range(4)) - 2, 0, MAX_VOLT);
    else
      v = $urandom_range(MAX_VOLT);
    if ($urandom_range(99) < 5) gen_present = ~gen_present;
    chg = ($urandom_range(99) < 4);
    th  = $urandom_range(3) == 0 ?
          clamp(int'(cfg.reduced_current) + int'($urandom_range(4)) - 2, 0, 4095) :
          int'($urandom_range(4095));
    mx  = $urandom_range(4095);
    return mk_sample(t, v, int'(gen_present), int'(chg), th, mx);
  endfunction

  // APB write: setup then access; lands at the edge with penable high
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COLD_LIMIT:      cfg.cold_limit      = val[7:0];
      REG_NORMAL_LIMIT:    cfg.normal_limit    = val[7:0];
      REG_WARM_LIMIT:      cfg.warm_limit      = val[7:0];
      REG_HOT_LIMIT:       cfg.hot_limit       = val[7:0];
      REG_VOLTAGE_LIMIT:   cfg.voltage_limit   = val[22:0];
      REG_REDUCED_CURRENT: cfg.reduced_current = val[11:0];
      REG_DEFAULT_CURRENT: cfg.default_current = val[11:0];
      REG_FILTER_ENABLE:   cfg.filter_enable   = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(REG_COLD_LIMIT,      {24'd0, c.cold_limit});
    write_reg(REG_NORMAL_LIMIT,    {24'd0, c.normal_limit});
    write_reg(REG_WARM_LIMIT,      {24'd0, c.warm_limit});
    write_reg(REG_HOT_LIMIT,       {24'd0, c.hot_limit});
    write_reg(REG_VOLTAGE_LIMIT,   {9'd0, c.voltage_limit});
    write_reg(REG_REDUCED_CURRENT, {20'd0, c.reduced_current});
    write_reg(REG_DEFAULT_CURRENT, {20'd0, c.default_current});
    write_reg(REG_FILTER_ENABLE,   {31'd0, c.filter_enable});
    settings_used++;
  endtask

  // ordered limits keep all five bands reachable; unordered ones test priority
  function automatic cfg_t rand_cfg(bit ordered);
    cfg_t c;
    int   base;
    if (ordered) begin
      base           = int'($urandom_range(60)) - 40;
      c.cold_limit   = base[7:0];
      base           = base + 5 + int'($urandom_range(40));
      c.normal_limit = base[7:0];
      base           = base + 1 + int'($urandom_range(8));
      c.warm_limit   = base[7:0];
      base           = base + 1 + int'($urandom_range(10));
      c.hot_limit    = base[7:0];
    end else begin
      c.cold_limit   = 8'($urandom_range(255));
      c.normal_limit = 8'($urandom_range(255));
      c.warm_limit   = 8'($urandom_range(255));
      c.hot_limit    = 8'($urandom_range(255));
    end
    c.voltage_limit   = 23'($urandom_range(MAX_VOLT));
    c.reduced_current = 12'($urandom_range(4095));
    c.default_current = 12'($urandom_range(4095));
    c.filter_enable   = 1'($urandom_range(1));
    return c;
  endfunction

  // block is idle once every sample is in and every result is back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid || policy_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(int sel);
    case (sel)
      0:       begin send_idle_pct = 34; recv_idle_pct = 82; end
      1:       begin send_idle_pct = 82; recv_idle_pct = 34; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  // Input driver: a new transfer is offered only once the last one is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        policy_results_q.push_back(charge_policy_step(in_data));
        samples_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (policy_results_q.size() == 0) begin
          $display("%0t: result with none outstanding, actual %h", $time, out_data_o);
          error_count++;
        end else begin
          want = policy_results_q.pop_front();
          check_field("charge_state",     want.charge_state,     out_data_o.charge_state);
          check_field("transition",       want.transition,       out_data_o.transition);
          check_field("update_req",       want.update_req,       out_data_o.update_req);
          check_field("disable_charging", want.disable_charging,
                      out_data_o.disable_charging);
          check_field("drive_current",    want.drive_current,    out_data_o.drive_current);
          check_field("health",           want.health,           out_data_o.health);
          check_field("pseudo_charging",  want.pseudo_charging,  out_data_o.pseudo_charging);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               policy_results_q.size());
      $display("[battery_thermal_charge_policy_core] ERROR");
      $finish;
    end
  end

  // Stimulus: directed walk through the state machine, then random phases.
  initial begin
    cfg_t c;
    reset_policy();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);

    pending_samples.push_back(mk_sample(25, 3800000, 1, 0, 1500, 2000)); // attach
    pending_samples.push_back(mk_sample(127, 3800000, 1, 0, 1500, 2000)); // overheat
    pending_samples.push_back(mk_sample(-128, 3800000, 1, 0, 1500, 2000)); // cold stopped
    pending_samples.push_back(mk_sample(20, 3800000, 1, 0, 1500, 2000)); // stop to normal
    pending_samples.push_back(mk_sample(48, 3800000, 1, 0, 1500, 2000)); // to reduced
    pending_samples.push_back(mk_sample(49, 4500000, 1, 0, 1500, 2000)); // held, high v, stops
    pending_samples.push_back(mk_sample(49, 4500000, 1, 0, 1500, 2000)); // stopped, pseudo
    pending_samples.push_back(mk_sample(48, 3000000, 1, 0, 1500, 2000)); // stop to reduced
    pending_samples.push_back(mk_sample(42, 3000000, 1, 0, 300, 2000)); // warm hold
    pending_samples.push_back(mk_sample(42, 4100000, 1, 0, 300, 2000)); // red to stop
    pending_samples.push_back(mk_sample(30, 4100000, 1, 0, 300, 2000)); // stop to normal
    pending_samples.push_back(mk_sample(43, 3000000, 1, 0, 300, 2000)); // warm normal
    pending_samples.push_back(mk_sample(50, 4000000, 1, 0, 300, 2000)); // volt at limit
    pending_samples.push_back(mk_sample(30, 3000000, 1, 1, 700, 2000)); // change event
    pending_samples.push_back(mk_sample(46, 3000000, 1, 0, 700, 2000)); // to reduced
    pending_samples.push_back(mk_sample(-20, 3000000, 1, 0, 700, 2000)); // cold in reduced
    pending_samples.push_back(mk_sample(-20, 3000000, 1, 0, 700, 2000)); // then stops
    pending_samples.push_back(mk_sample(25, 3000000, 0, 0, 700, 2000)); // charger gone
    pending_samples.push_back(mk_sample(127, MAX_VOLT, 1, 1, 4095, 4095)); // field maxima, voltage at MAX_VOLT
    pending_samples.push_back(mk_sample(-128, 0, 0, 0, 0, 0)); // field minima
    pending_samples.push_back(mk_sample(25, 3000000, 1, 0, 3000, 1200)); // capped by max
    pending_samples.push_back(mk_sample(46, 3000000, 1, 0, 4000, 4000)); // capped reduced
    pending_samples.push_back(mk_sample(45, 3000000, 1, 0, 4000, 4000)); // small drop held
    pending_samples.push_back(mk_sample(46, 3000000, 1, 0, 4000, 4000)); // repeat passes
    gen_temp    = 46;
    gen_present = 1'b1;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: c = CFG_RESET;
        1: c = rand_cfg(1'b1);
        2: c = '{cold_limit: -8'sd128, normal_limit: -8'sd128, warm_limit: -8'sd128,
                 hot_limit: -8'sd128, voltage_limit: '0, reduced_current: '0,
                 default_current: '0, filter_enable: 1'b0};
        3: c = '{cold_limit: 8'sd127, normal_limit: 8'sd127, warm_limit: 8'sd127,
                 hot_limit: 8'sd127, voltage_limit: 23'(MAX_VOLT), reduced_current: '1,
                 default_current: '1, filter_enable: 1'b1};
        4: c = rand_cfg(1'b0);
        default: begin
          c                 = CFG_RESET;
          c.filter_enable   = 1'b0;
          c.reduced_current = '1;
          c.default_current = '0;
        end
      endcase
      apply_cfg(c);
      set_idling(ph % 3);
      repeat (PHASE_SAMPLES) pending_samples.push_back(gen_sample());
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d samples and %0d results across %0d register settings,",
             samples_taken, results_seen, settings_used);
    $display("with sender and receiver stalls swapped and a stall-free stretch.");
    if (error_count == 0) begin
      $display("[battery_thermal_charge_policy_core] OK");
    end else begin
      $display("[battery_thermal_charge_policy_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/btcp_pkg.sv
src/btcp_cfg_regs.sv
src/btcp_temp_band.sv
src/btcp_policy.sv
src/battery_thermal_charge_policy_core.sv
test/battery_thermal_charge_policy_core_tb.sv
